### design/bll_pkg.sv
package bll_pkg;

	// Field widths of one input item and one result item.
	localparam int SOC_W   = 7;
	localparam int RAW_W   = 16;
	localparam int RANGE_W = 2;
	localparam int MODE_W  = 3;
	localparam int LEVEL_W = 2;

	// Packed stream widths.
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 24;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_R0_VALID_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_R0_VALID_MAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_R12_VALID_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_R12_VALID_MAX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_R0_DIS_BELOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_R1_DIS_BELOW  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_R2_DIS_BELOW  = 3'd6;

	localparam logic [CFG_DATA_W-1:0] CFG_ALL_ONES = 16'hFFFF;

	// The quotient of the average always fits the raw width, so the divider
	// retires one quotient bit per step over that many steps.
	localparam int DIV_STEPS = RAW_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// Range codes.
	localparam logic [RANGE_W-1:0] RANGE_0 = 2'd0;
	localparam logic [RANGE_W-1:0] RANGE_1 = 2'd1;
	localparam logic [RANGE_W-1:0] RANGE_2 = 2'd2;

	// Power mode codes; off, acc and on are the active modes.
	localparam logic [MODE_W-1:0] MODE_OFF = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ACC = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ON  = 3'd2;

	// Limit levels.
	localparam logic [LEVEL_W-1:0] LEVEL_0 = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_1 = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_2 = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_3 = 2'd3;

	// State-of-charge hysteresis points in percent.
	localparam logic [SOC_W-1:0] SOC_L1_ENTER_HI = 7'd55;
	localparam logic [SOC_W-1:0] SOC_L1_ENTER_LO = 7'd50;
	localparam logic [SOC_W-1:0] SOC_L1_EXIT     = 7'd57;
	localparam logic [SOC_W-1:0] SOC_L2_ENTER_LO = 7'd45;
	localparam logic [SOC_W-1:0] SOC_L2_EXIT     = 7'd52;
	localparam logic [SOC_W-1:0] SOC_L3_EXIT     = 7'd47;
	localparam logic [SOC_W-1:0] SOC_NONE        = 7'd0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic div_init;
		logic div_step;
		logic finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

### design/bll_ctrl.sv
module bll_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  bll_pkg::status_t status,
	output bll_pkg::cmd_t   cmd
);
	import bll_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [1:0]        state_d;
	logic [STEP_W-1:0] step_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd.capture  = 1'b0;
		cmd.div_init = 1'b0;
		cmd.div_step = 1'b0;
		cmd.finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule

### design/bll_dp.sv
module bll_dp #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bll_pkg::cmd_t                    cmd,
	output bll_pkg::status_t                 status,
	input  logic [bll_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic [bll_pkg::RANGE_W-1:0]      s_tuser,
	input  logic                             cfg_valid,
	input  logic [bll_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bll_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bll_pkg::M_TDATA_W-1:0]    m_tdata
);
	import bll_pkg::*;

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W = RAW_W + CNT_W;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] r0_min_q, r0_max_q, r12_min_q, r12_max_q;
	logic [CFG_DATA_W-1:0] r0_dis_q, r1_dis_q, r2_dis_q;

	// Sample ring and its running sum.
	logic [RAW_W-1:0] ring_q [WINDOW_DEPTH];
	logic [IDX_W-1:0] slot_q;
	logic [CNT_W-1:0] held_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_d;
	logic             ring_full;

	// Captured tick fields.
	logic [SOC_W-1:0]   soc_q;
	logic [RANGE_W-1:0] range_q;
	logic [MODE_W-1:0]  mode_q;
	logic               init_q;
	logic               asleep_q;

	// Divider.
	logic [CNT_W-1:0] rem_q;
	logic [RAW_W-1:0] quo_q;
	logic [CNT_W:0]   rem_shift;
	logic [CNT_W:0]   rem_diff;
	logic             quo_bit;

	// Decision logic.
	logic [LEVEL_W-1:0] level_q, level_d;
	logic               warn_q, warn_d;
	logic               dis;
	logic               active;

	logic [RAW_W-1:0] raw_in;
	assign raw_in = s_tdata[22:7];

	assign status.out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_min_q  <= '0;
			r0_max_q  <= CFG_ALL_ONES;
			r12_min_q <= '0;
			r12_max_q <= CFG_ALL_ONES;
			r0_dis_q  <= '0;
			r1_dis_q  <= '0;
			r2_dis_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_R0_VALID_MIN:  r0_min_q  <= cfg_data;
				REG_R0_VALID_MAX:  r0_max_q  <= cfg_data;
				REG_R12_VALID_MIN: r12_min_q <= cfg_data;
				REG_R12_VALID_MAX: r12_max_q <= cfg_data;
				REG_R0_DIS_BELOW:  r0_dis_q  <= cfg_data;
				REG_R1_DIS_BELOW:  r1_dis_q  <= cfg_data;
				REG_R2_DIS_BELOW:  r2_dis_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Once the ring is full the new sample displaces the oldest one, which
	// sits in the slot about to be written.
	assign ring_full = (held_q == CNT_W'(WINDOW_DEPTH));
	assign sum_d = sum_q + SUM_W'(raw_in)
		- (ring_full ? SUM_W'(ring_q[slot_q]) : SUM_W'(0));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ring_q[slot_q] <= raw_in;
			soc_q          <= s_tdata[6:0];
			range_q        <= s_tuser;
			mode_q         <= s_tdata[25:23];
			init_q         <= s_tdata[26];
			asleep_q       <= s_tdata[27];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			held_q <= '0;
			sum_q  <= '0;
		end else if (cmd.capture) begin
			sum_q  <= sum_d;
			slot_q <= (slot_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			if (!ring_full) begin
				held_q <= held_q + 1'b1;
			end
		end
	end

	// Restoring division of the sum by the sample count. The sum is below
	// held * 2^16, so its upper bits start as a partial remainder below the
	// divisor and only sixteen quotient bits remain.
	assign rem_shift = {rem_q, quo_q[RAW_W-1]};
	assign rem_diff  = rem_shift - {1'b0, held_q};
	assign quo_bit   = (rem_shift >= {1'b0, held_q});

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= sum_q[SUM_W-1:RAW_W];
			quo_q <= sum_q[RAW_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= quo_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
			quo_q <= {quo_q[RAW_W-2:0], quo_bit};
		end
	end

	always_comb begin
		case (range_q)
			RANGE_0: dis = (quo_q >= r0_min_q) && (quo_q <= r0_max_q)
				&& (quo_q < r0_dis_q);
			RANGE_1: dis = (quo_q >= r12_min_q) && (quo_q <= r12_max_q)
				&& (quo_q < r1_dis_q);
			RANGE_2: dis = (quo_q >= r12_min_q) && (quo_q <= r12_max_q)
				&& (quo_q < r2_dis_q);
			default: dis = 1'b0;
		endcase
	end

	assign active = (mode_q == MODE_OFF) || (mode_q == MODE_ACC) || (mode_q == MODE_ON);

	always_comb begin
		level_d = level_q;
		if (active) begin
			case (level_q)
				LEVEL_0: begin
					if (soc_q <= SOC_L1_ENTER_HI && soc_q > SOC_L1_ENTER_LO && dis) begin
						level_d = LEVEL_1;
					end
				end
				LEVEL_1: begin
					if (soc_q >= SOC_L1_EXIT) begin
						level_d = LEVEL_0;
					end else if (soc_q <= SOC_L1_ENTER_LO && soc_q > SOC_L2_ENTER_LO
						&& dis) begin
						level_d = LEVEL_2;
					end
				end
				LEVEL_2: begin
					if (soc_q >= SOC_L2_EXIT) begin
						level_d = LEVEL_1;
					end else if (soc_q <= SOC_L2_ENTER_LO && dis) begin
						level_d = LEVEL_3;
					end
				end
				default: begin
					if (soc_q >= SOC_L3_EXIT) begin
						level_d = LEVEL_2;
					end
				end
			endcase
		end
	end

	always_comb begin
		warn_d = warn_q;
		if (soc_q != SOC_NONE && !init_q && !asleep_q && active) begin
			warn_d = (level_d != LEVEL_0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= LEVEL_0;
			warn_q   <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.finish) begin
				level_q  <= level_d;
				warn_q   <= warn_d;
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			m_tdata <= {4'b0000, dis, quo_q, warn_d, level_d};
		end
	end

endmodule

### design/battery_load_limit_level.sv
// Channel   Direction  Signals                                  Content
// s_        in         s_tvalid s_tready s_tdata s_tuser        one tick per beat
// m_        out        m_tvalid m_tready m_tdata                one result per beat
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data   register writes
//
// An input beat is taken in the idle state; the next one waits until this tick is done:
// the block stores the sample and updates the running sum, loads the
// divider, runs the bit-serial restoring divide of the sum by the sample
// count, and then applies the discharge test and level machine and fills the
// output register.
// Reset clears the ring pointer, sample count, running sum, level and warning,
// and returns the configuration registers to their defaults; sample storage is
// not cleared.
// A stalled result waits in the output register; the block still accepts the
// next tick and stalls only in its last cycle until the register frees.
module battery_load_limit_level #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [6:0] charge_percent, [22:7] raw_current, [25:23] power_mode,
	// [26] manager_initializing, [27] network_asleep, [31:28] zero
	input  logic [bll_pkg::S_TDATA_W-1:0]  s_tdata,
	// [1:0] current_range
	input  logic [bll_pkg::RANGE_W-1:0]    s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [1:0] limit_level, [2] low_battery_warning, [18:3] average_current,
	// [19] discharging, [23:20] zero
	output logic [bll_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bll_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bll_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bll_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Register writes are always taken; send them only while idle, as the block does not enforce it.
	assign cfg_ready = 1'b1;

	bll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bll_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

`ifndef ASSERT_OFF
	// Only one tick is worked on at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a tick is still in progress");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid || m_tready))
		else $error("result written over an untaken result");

	// The controller issues at most one command per cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.div_init, cmd.div_step, cmd.finish}))
		else $error("conflicting datapath commands");

	// A result is never produced while the block is idle.
	a_finish_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !s_tready)
		else $error("result produced while idle");
`endif

endmodule

### tb/battery_load_limit_level_tb.sv
`timescale 1ns / 1ps

module battery_load_limit_level_tb;
	import bll_pkg::*;

	localparam int RING_DEPTH    = 10;
	localparam int NUM_CFG_REGS  = 7;
	// This pause covers one tick that is still in flight, with a good margin.
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 5000;

	// Codes that the package leaves unnamed.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED     = 3'd7;
	localparam logic [RANGE_W-1:0]   RANGE_BAD_CODE = 2'd3;
	localparam logic [MODE_W-1:0]    MODE_START     = 3'd3;
	localparam logic [MODE_W-1:0]    MODE_OTHER_LO  = 3'd4;
	localparam logic [MODE_W-1:0]    MODE_CODE_MAX  = 3'd7;

	// One result beat, split into its fields.
	typedef struct {
		logic [LEVEL_W-1:0] level;
		logic               warning;
		logic [RAW_W-1:0]   avg;
		logic               dis;
	} limit_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic [RANGE_W-1:0]    s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Our own copy of the block's state: the current ring, the limit
	// machine and the configuration registers as last written.
	logic [RAW_W-1:0]      ring_samples [RING_DEPTH];
	int                    ring_slot;
	int                    ring_held;
	logic [LEVEL_W-1:0]    level_state;
	logic                  warning_state;
	logic [CFG_DATA_W-1:0] limit_regs [NUM_CFG_REGS];

	// Results predicted for accepted ticks, oldest first.
	limit_result_t pending_limit_results [$];
	limit_result_t arrived_want;

	int  mismatch_count;
	int  results_seen;
	int  hold_cycles;
	// When low, neither side inserts idle cycles.
	bit  idle_on;

	battery_load_limit_level #(
		.WINDOW_DEPTH(RING_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// The run must end well before this; reaching it means a hang.
	initial begin
		#15_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void log_mismatch(input string what, input longint unsigned want,
		input longint unsigned got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: mismatch on %s at result %0d: expected 'h%0h, got 'h%0h",
				$realtime, what, results_seen, want, got);
		end
	endfunction

	// Idle lengths: mostly a few cycles, now and then a long stretch.
	function automatic int random_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 15);
		end
		return $urandom_range(20, 60);
	endfunction

	// Advances our copy of the block by one tick and returns what the block
	// has to report for it. The ring is only summed over entries written so
	// far, and the average is the floor of sum over held count.
	function automatic limit_result_t predict_limit_result(input logic [SOC_W-1:0] soc,
		input logic [RAW_W-1:0] raw, input logic [RANGE_W-1:0] rng,
		input logic [MODE_W-1:0] mode, input logic init, input logic asleep);
		limit_result_t r;
		logic [31:0] sum;
		logic [31:0] avg;
		logic        active;
		int          i;
		sum = 0;
		ring_samples[ring_slot] = raw;
		ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
		if (ring_held < RING_DEPTH) begin
			ring_held++;
		end
		for (i = 0; i < ring_held; i++) begin
			sum += ring_samples[i];
		end
		avg = sum / ring_held;
		r.avg = avg[RAW_W-1:0];

		// Range 2 shares the window of range 1 but has its own threshold.
		case (rng)
			RANGE_0: begin
				r.dis = avg >= limit_regs[REG_R0_VALID_MIN] && avg <= limit_regs[REG_R0_VALID_MAX]
					&& avg < limit_regs[REG_R0_DIS_BELOW];
			end
			RANGE_1: begin
				r.dis = avg >= limit_regs[REG_R12_VALID_MIN]
					&& avg <= limit_regs[REG_R12_VALID_MAX] && avg < limit_regs[REG_R1_DIS_BELOW];
			end
			RANGE_2: begin
				r.dis = avg >= limit_regs[REG_R12_VALID_MIN]
					&& avg <= limit_regs[REG_R12_VALID_MAX] && avg < limit_regs[REG_R2_DIS_BELOW];
			end
			default: begin
				r.dis = 1'b0;
			end
		endcase

		// The limit machine only moves in off, acc and on.
		active = (mode <= MODE_ON);
		if (active) begin
			case (level_state)
				LEVEL_0: begin
					if (soc <= SOC_L1_ENTER_HI && soc > SOC_L1_ENTER_LO && r.dis) begin
						level_state = LEVEL_1;
					end
				end
				LEVEL_1: begin
					if (soc >= SOC_L1_EXIT) begin
						level_state = LEVEL_0;
					end else if (soc <= SOC_L1_ENTER_LO && soc > SOC_L2_ENTER_LO && r.dis) begin
						level_state = LEVEL_2;
					end
				end
				LEVEL_2: begin
					if (soc >= SOC_L2_EXIT) begin
						level_state = LEVEL_1;
					end else if (soc <= SOC_L2_ENTER_LO && r.dis) begin
						level_state = LEVEL_3;
					end
				end
				default: begin
					if (soc >= SOC_L3_EXIT) begin
						level_state = LEVEL_2;
					end
				end
			endcase
		end

		// A missing charge reading, an initializing manager or a sleeping
		// network freezes the warning; so does any inactive power mode.
		if (soc != SOC_NONE && !init && !asleep && active) begin
			warning_state = (level_state != LEVEL_0);
		end
		r.level   = level_state;
		r.warning = warning_state;
		return r;
	endfunction

	// Sends one tick. Valid is left high after the beat is taken; the next
	// call either keeps it high or drops it for a gap, so that it never gets
	// two assignments in one time step.
	task automatic send_tick(input logic [SOC_W-1:0] soc, input logic [RAW_W-1:0] raw,
		input logic [RANGE_W-1:0] rng, input logic [MODE_W-1:0] mode, input logic init,
		input logic asleep);
		int gap;
		if (idle_on && $urandom_range(0, 1) == 1) begin
			gap = random_pause();
		end else begin
			gap = 0;
		end
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, asleep, init, mode, raw, soc};
		s_tuser  <= rng;
		do @(posedge clk); while (!s_tready);
		pending_limit_results.push_back(predict_limit_result(soc, raw, rng, mode, init, asleep));
	endtask

	// Lowers valid, waits for every predicted result and lets the block settle.
	task automatic wait_for_results();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (pending_limit_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		// Writes beyond the last register are dropped by the block.
		if (idx < NUM_CFG_REGS) begin
			limit_regs[idx] = value;
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Programs all seven registers once the block is idle, then pokes the
	// unused index with random data, which must change nothing.
	task automatic program_settings(input logic [15:0] r0_min, input logic [15:0] r0_max,
		input logic [15:0] r12_min, input logic [15:0] r12_max, input logic [15:0] below0,
		input logic [15:0] below1, input logic [15:0] below2);
		wait_for_results();
		write_reg(REG_R0_VALID_MIN, r0_min);
		write_reg(REG_R0_VALID_MAX, r0_max);
		write_reg(REG_R12_VALID_MIN, r12_min);
		write_reg(REG_R12_VALID_MAX, r12_max);
		write_reg(REG_R0_DIS_BELOW, below0);
		write_reg(REG_R1_DIS_BELOW, below1);
		write_reg(REG_R2_DIS_BELOW, below2);
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
	endtask

	// Random ticks. Most of them follow a slow walk of the charge reading
	// around the hysteresis points with currents in a band near the
	// thresholds, so that the limit machine climbs and falls; the rest are
	// noise over every value the fields can hold.
	task automatic run_random_ticks(input int count, input int raw_lo, input int raw_hi);
		logic [SOC_W-1:0]   soc;
		logic [RAW_W-1:0]   raw;
		logic [RANGE_W-1:0] rng;
		logic [MODE_W-1:0]  mode;
		logic               init;
		logic               asleep;
		int                 soc_walk;
		int                 n;
		soc_walk = $urandom_range(40, 62);
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 85) begin
				soc_walk = soc_walk + $urandom_range(0, 4) - 2;
				if (soc_walk < 38) begin
					soc_walk = 38;
				end else if (soc_walk > 62) begin
					soc_walk = 62;
				end
				soc    = ($urandom_range(0, 19) == 0) ? SOC_NONE : SOC_W'(soc_walk);
				raw    = RAW_W'($urandom_range(raw_lo, raw_hi));
				rng    = ($urandom_range(0, 19) == 0) ? RANGE_BAD_CODE
					: RANGE_W'($urandom_range(0, 2));
				mode   = ($urandom_range(0, 9) == 0) ? MODE_W'($urandom_range(3, 7))
					: MODE_W'($urandom_range(0, 2));
				init   = ($urandom_range(0, 19) == 0);
				asleep = ($urandom_range(0, 19) == 0);
			end else begin
				soc    = SOC_W'($urandom);
				raw    = RAW_W'($urandom);
				rng    = RANGE_W'($urandom);
				mode   = MODE_W'($urandom);
				init   = 1'($urandom);
				asleep = 1'($urandom);
			end
			send_tick(soc, raw, rng, mode, init, asleep);
		end
	endtask

	// With the reset thresholds nothing counts as discharge. The ring fills
	// from one sample to ten, with the average taken over the held samples
	// only, and then wraps so that the first sample drops out. Power modes,
	// invalid range and the gating flags are all visited on the way.
	task automatic test_ring_average();
		send_tick(SOC_NONE, 16'h0000, RANGE_0, MODE_OFF, 1'b0, 1'b0);
		send_tick(7'd100, 16'hFFFF, RANGE_1, MODE_ACC, 1'b0, 1'b0);
		send_tick(7'd127, 16'hFFFF, RANGE_2, MODE_ON, 1'b1, 1'b0);
		send_tick(7'd55, 16'hFFFF, RANGE_BAD_CODE, MODE_START, 1'b0, 1'b1);
		send_tick(7'd53, 16'hFFFF, RANGE_0, MODE_OTHER_LO, 1'b0, 1'b0);
		send_tick(7'd1, 16'hFFFF, RANGE_1, MODE_CODE_MAX, 1'b1, 1'b1);
		send_tick(7'd64, 16'hFFFF, RANGE_2, MODE_ON, 1'b0, 1'b0);
		send_tick(7'd57, 16'hFFFF, RANGE_BAD_CODE, MODE_CODE_MAX, 1'b0, 1'b0);
		send_tick(7'd50, 16'hFFFF, RANGE_0, MODE_OFF, 1'b0, 1'b0);
		send_tick(7'd45, 16'hFFFF, RANGE_1, MODE_ACC, 1'b0, 1'b0);
		send_tick(7'd46, 16'hFFFF, RANGE_2, MODE_ON, 1'b0, 1'b0);
	endtask

	// Every average below full scale now counts as discharge in a valid
	// range, so the level walks up through all four levels as the charge
	// drops and back down through each exit point. Along the way: an invalid
	// range and an inactive mode block the step, the gating flags freeze the
	// warning, and a missing charge reading holds both.
	task automatic test_level_hysteresis();
		program_settings(16'h0000, CFG_ALL_ONES, 16'h0000, CFG_ALL_ONES, CFG_ALL_ONES,
			CFG_ALL_ONES, CFG_ALL_ONES);
		send_tick(7'd53, 16'h0000, RANGE_BAD_CODE, MODE_OFF, 1'b0, 1'b0);
		send_tick(7'd53, 16'h0000, RANGE_0, MODE_START, 1'b0, 1'b0);
		send_tick(7'd53, 16'h0000, RANGE_0, MODE_ACC, 1'b1, 1'b0);
		send_tick(7'd48, 16'h0000, RANGE_1, MODE_ON, 1'b0, 1'b0);
		send_tick(7'd40, 16'h0000, RANGE_2, MODE_OFF, 1'b0, 1'b1);
		send_tick(SOC_NONE, 16'h0000, RANGE_0, MODE_OFF, 1'b0, 1'b0);
		send_tick(7'd47, 16'h0000, RANGE_0, MODE_ON, 1'b0, 1'b0);
		send_tick(7'd52, 16'h0000, RANGE_0, MODE_ON, 1'b0, 1'b0);
		send_tick(7'd56, 16'h0000, RANGE_0, MODE_ON, 1'b0, 1'b0);
		send_tick(7'd57, 16'h0000, RANGE_0, MODE_ACC, 1'b0, 1'b0);
	endtask

	// Plausible windows with staggered thresholds and currents around them.
	task automatic test_typical_thresholds();
		program_settings(16'd2000, 16'd60000, 16'd1000, 16'd62000, 16'd20000, 16'd30000, 16'd40000);
		run_random_ticks(120, 10000, 50000);
	endtask

	// Windows turned inside out, windows of a single value, thresholds that
	// nothing is below, and thresholds that almost everything is below.
	task automatic test_window_extremes();
		program_settings(CFG_ALL_ONES, 16'h0000, CFG_ALL_ONES, 16'h0000, CFG_ALL_ONES,
			CFG_ALL_ONES, CFG_ALL_ONES);
		run_random_ticks(40, 0, 65535);
		program_settings(16'h0000, 16'h0000, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES,
			CFG_ALL_ONES, CFG_ALL_ONES);
		run_random_ticks(40, 0, 3);
		program_settings(16'h0000, CFG_ALL_ONES, 16'h0000, CFG_ALL_ONES, 16'h0000, 16'h0000,
			16'h0000);
		run_random_ticks(40, 0, 65535);
		program_settings(16'h0000, CFG_ALL_ONES, 16'h0000, CFG_ALL_ONES, CFG_ALL_ONES,
			CFG_ALL_ONES, CFG_ALL_ONES);
		run_random_ticks(40, 60000, 65535);
	endtask

	// Registers drawn at random, with currents over the whole scale.
	task automatic test_random_settings();
		int k;
		for (k = 0; k < 3; k++) begin
			program_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
				CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
				CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
			run_random_ticks(40, 0, 65535);
		end
	endtask

	// Ticks offered back to back with the result side always ready.
	task automatic test_no_idling();
		program_settings(16'd0, 16'd50000, 16'd5000, CFG_ALL_ONES, 16'd30000, 16'd25000, 16'd35000);
		idle_on = 1'b0;
		run_random_ticks(60, 15000, 45000);
		wait_for_results();
		idle_on = 1'b1;
	endtask

	// Result side: each beat is checked against the oldest prediction, and
	// ready drops now and then for a random number of cycles.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_limit_results.size() == 0) begin
				log_mismatch("result beat with nothing expected", 0, m_tdata);
			end else begin
				arrived_want = pending_limit_results.pop_front();
				if (m_tdata[1:0] !== arrived_want.level) begin
					log_mismatch("limit_level", arrived_want.level, m_tdata[1:0]);
				end
				if (m_tdata[2] !== arrived_want.warning) begin
					log_mismatch("low_battery_warning", arrived_want.warning, m_tdata[2]);
				end
				if (m_tdata[18:3] !== arrived_want.avg) begin
					log_mismatch("average_current", arrived_want.avg, m_tdata[18:3]);
				end
				if (m_tdata[19] !== arrived_want.dis) begin
					log_mismatch("discharging", arrived_want.dis, m_tdata[19]);
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles--;
		end else if (idle_on && $urandom_range(0, 6) == 0) begin
			hold_cycles = random_pause();
		end
		m_tready <= (hold_cycles == 0);
	end

	initial begin
		int i;
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		idle_on   = 1'b1;
		hold_cycles    = 0;
		mismatch_count = 0;
		results_seen   = 0;

		// Reset state of the block: empty ring, level 0, no warning, and the
		// register defaults of full windows with zero thresholds.
		for (i = 0; i < RING_DEPTH; i++) begin
			ring_samples[i] = '0;
		end
		ring_slot     = 0;
		ring_held     = 0;
		level_state   = LEVEL_0;
		warning_state = 1'b0;
		limit_regs[REG_R0_VALID_MIN]  = 16'h0000;
		limit_regs[REG_R0_VALID_MAX]  = CFG_ALL_ONES;
		limit_regs[REG_R12_VALID_MIN] = 16'h0000;
		limit_regs[REG_R12_VALID_MAX] = CFG_ALL_ONES;
		limit_regs[REG_R0_DIS_BELOW]  = 16'h0000;
		limit_regs[REG_R1_DIS_BELOW]  = 16'h0000;
		limit_regs[REG_R2_DIS_BELOW]  = 16'h0000;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_ring_average();
		test_level_hysteresis();
		test_typical_thresholds();
		test_window_extremes();
		test_random_settings();
		test_no_idling();

		wait_for_results();
		if (pending_limit_results.size() != 0) begin
			log_mismatch("results never delivered", 0, pending_limit_results.size());
		end
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
